// ----- rtl/core/bfm_pkg.sv -----
`default_nettype none
package bfm_pkg;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } bfm_in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic [10:0] out_col;
    logic [15:0] out_row;
    logic        was_filtered;
    logic        last_of_item;
  } bfm_out_item_t;

  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [CfgIndexW-1:0] {
    REG_KERNEL_SIZE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } bfm_reg_t;

  localparam logic [3:0]  KernelReset = 4'd7;
  localparam logic [11:0] WidthReset  = 12'd640;
  localparam logic [15:0] HeightReset = 16'd480;
  localparam int unsigned DivSteps    = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SUM,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT_F
  } bfm_state_t;

  typedef struct packed {
    logic accept;
    logic load_border;
    logic rd_issue;
    logic div_load;
    logic div_step;
    logic load_filt;
  } bfm_cmd_t;

  typedef struct packed {
    logic out_free;
    logic border;
    logic interior;
    logic last_read;
    logic div_done;
  } bfm_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/bfm_stream_if.sv -----
`default_nettype none
interface bfm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bfm_ctrl.sv -----
`default_nettype none
module bfm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bfm_pkg::bfm_sts_t sts,
  output bfm_pkg::bfm_cmd_t      cmd
);
  import bfm_pkg::*;

  bfm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.border) begin
          if (sts.out_free) begin
            cmd.load_border = 1'b1;
            state_nxt       = sts.interior ? ST_SUM : ST_IDLE;
          end
        end else if (sts.interior) begin
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_read) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_EMIT_F;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT_F: begin
        if (sts.out_free) begin
          cmd.load_filt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/bfm_datapath.sv -----
`default_nettype none
module bfm_datapath #(
  parameter int unsigned MAX_KERNEL = 15,
  parameter int unsigned MAX_WIDTH  = 2048
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire bfm_pkg::bfm_in_item_t              in_item,
  input  wire logic                               cfg_we,
  input  wire logic [bfm_pkg::CfgIndexW-1:0]      cfg_index,
  input  wire logic [bfm_pkg::CfgDataW-1:0]       cfg_wdata,
  input  wire bfm_pkg::bfm_cmd_t                  cmd,
  output bfm_pkg::bfm_sts_t                       sts,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output bfm_pkg::bfm_out_item_t                  out_item
);
  import bfm_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned EW    = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int unsigned SW    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned Depth = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);

  logic [3:0]  kernel_r;
  logic [11:0] width_r;
  logic [15:0] height_r;

  logic [CW-1:0] cc_r;
  logic [15:0]   rc_r;
  logic [SW-1:0] slot_r;

  logic [7:0]    pix_r;
  logic [CW-1:0] col_r;
  logic [15:0]   row_r;
  logic          border_r;
  logic          interior_r;

  logic [3:0]    rj_r;
  logic [3:0]    ri_r;
  logic [SW-1:0] rs_r;
  logic [CW-1:0] rcol_r;
  logic [CW-1:0] cbase_r;
  logic          rd_vld_r;
  logic [7:0]    rd_data_r;
  logic [15:0]   sum_r;

  logic [15:0] dq_r;
  logic [7:0]  drem_r;
  logic [4:0]  dcnt_r;

  logic          out_valid_r;
  bfm_out_item_t out_r;

  logic [7:0] mem [Depth];

  logic [EW-1:0] w_eff;
  logic [16:0]   h_eff;
  logic [CW-1:0] c_c;
  logic [16:0]   r_c;
  logic [SW-1:0] s_c;
  logic [EW-1:0] c1;
  logic [CW-1:0] ncc;
  logic [16:0]   nr;
  logic [SW-1:0] ns;
  logic [2:0]    half;
  logic [3:0]    two_half;
  logic          filt;
  logic          border_c;
  logic          interior_c;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ksq;
  logic [8:0]    trial;
  logic          fits;
  logic          out_free;

  assign half     = kernel_r[3:1];
  assign two_half = {kernel_r[3:1], 1'b0};
  assign filt     = kernel_r[0] && ({1'b0, kernel_r} <= 5'(MAX_KERNEL));
  assign ksq      = {4'd0, kernel_r} * {4'd0, kernel_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= KernelReset;
      width_r  <= WidthReset;
      height_r <= HeightReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_SIZE:  kernel_r <= cfg_wdata[3:0];
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[11:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = EW'(width_r);
    if (w_eff == '0) begin
      w_eff = EW'(1);
    end else if (w_eff > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end
    h_eff = {1'b0, height_r};
    if (h_eff == '0) begin
      h_eff = 17'd1;
    end

    if (in_item.frame_start) begin
      c_c = '0;
      r_c = '0;
      s_c = '0;
    end else begin
      c_c = cc_r;
      r_c = {1'b0, rc_r};
      s_c = slot_r;
      if (EW'(cc_r) >= w_eff) begin
        c_c = '0;
        r_c = r_c + 17'd1;
        s_c = (s_c == SW'(MAX_KERNEL - 1)) ? '0 : s_c + SW'(1);
      end
      if (r_c >= h_eff) begin
        r_c = '0;
        s_c = '0;
      end
    end
    if (s_c > SW'(MAX_KERNEL - 1)) begin
      s_c = '0;
    end

    c1  = EW'(c_c) + EW'(1);
    ncc = CW'(c1);
    nr  = r_c;
    ns  = s_c;
    if (c1 >= w_eff) begin
      ncc = '0;
      nr  = r_c + 17'd1;
      ns  = (s_c == SW'(MAX_KERNEL - 1)) ? '0 : s_c + SW'(1);
      if (nr >= h_eff) begin
        nr = '0;
        ns = '0;
      end
    end

    border_c = !filt || (EW'(c_c) < EW'(half)) || (r_c < 17'(half)) ||
               (EW'(c_c) + EW'(half) >= w_eff) || (r_c + 17'(half) >= h_eff);
    interior_c = filt && (EW'(c_c) >= EW'(two_half)) && (r_c >= 17'(two_half));

    wr_addr = AW'(AW'(s_c) * AW'(MAX_WIDTH) + AW'(c_c));
    rd_addr = AW'(AW'(rs_r) * AW'(MAX_WIDTH) + AW'(rcol_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wr_addr] <= in_item.pixel_in;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r     <= '0;
      rc_r     <= '0;
      slot_r   <= '0;
      rd_vld_r <= 1'b0;
      dcnt_r   <= '0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      if (cmd.accept) begin
        cc_r   <= ncc;
        rc_r   <= nr[15:0];
        slot_r <= ns;
      end
      if (cmd.div_load) begin
        dcnt_r <= 5'(DivSteps);
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r      <= in_item.pixel_in;
      col_r      <= c_c;
      row_r      <= r_c[15:0];
      border_r   <= border_c;
      interior_r <= interior_c;
      rj_r       <= '0;
      ri_r       <= '0;
      rs_r       <= s_c;
      rcol_r     <= c_c - CW'(two_half);
      cbase_r    <= c_c - CW'(two_half);
      sum_r      <= '0;
    end else begin
      if (cmd.rd_issue) begin
        if (ri_r == kernel_r - 4'd1) begin
          ri_r   <= '0;
          rj_r   <= rj_r + 4'd1;
          rcol_r <= cbase_r;
          rs_r   <= (rs_r == '0) ? SW'(MAX_KERNEL - 1) : rs_r - SW'(1);
        end else begin
          ri_r   <= ri_r + 4'd1;
          rcol_r <= rcol_r + CW'(1);
        end
      end
      if (rd_vld_r) begin
        sum_r <= sum_r + 16'(rd_data_r);
      end
    end
  end

  assign trial = {drem_r, dq_r[15]};
  assign fits  = trial >= {1'b0, ksq};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq_r   <= sum_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r   <= {dq_r[14:0], fits};
      drem_r <= fits ? 8'(trial - {1'b0, ksq}) : trial[7:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_border || cmd.load_filt) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_border) begin
      out_r.pixel_out    <= pix_r;
      out_r.out_col      <= 11'(col_r);
      out_r.out_row      <= row_r;
      out_r.was_filtered <= 1'b0;
      out_r.last_of_item <= !interior_r;
    end else if (cmd.load_filt) begin
      out_r.pixel_out    <= dq_r[7:0];
      out_r.out_col      <= 11'(col_r - CW'(half));
      out_r.out_row      <= row_r - 16'(half);
      out_r.was_filtered <= 1'b1;
      out_r.last_of_item <= 1'b1;
    end
  end

  assign sts.out_free  = out_free;
  assign sts.border    = border_r;
  assign sts.interior  = interior_r;
  assign sts.last_read = (rj_r == kernel_r - 4'd1) && (ri_r == kernel_r - 4'd1);
  assign sts.div_done  = (dcnt_r == '0);

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

// ----- rtl/core/box_filter_2d_mean_unit.sv -----
// K by K mean filter over a raster stream of 8-bit grayscale pixels.
// in_ch carries one pixel and a frame start flag per transfer (valid/ready).
// out_ch carries results: pixel, column, row, filtered flag and a flag on
// the last result a pixel causes. A pixel yields zero, one or two results:
// its own copy if it lies within K/2 of an edge (every pixel if K is even or
// above MAX_KERNEL), then the window mean of the pixel K/2 columns left and
// K/2 rows up once that window is complete. Configuration (kernel size,
// width, height) is written through cfg_we, cfg_index and cfg_wdata; the
// user must write it only while the block is idle, as the block itself
// does not enforce this. A pixel with no window mean goes from the decide
// state back to idle. A pixel that completes a window is summed by K*K
// reads of the single-port line store and divided by a 16-step serial
// divider; no new pixel is taken until its mean is loaded. The first
// result is valid in the cycle after the output register is loaded. Reset
// clears the position counters and the output valid flag and restores
// K = 7, 640 x 480. The line store is not cleared. A stalled receiver holds
// the output register; the block then waits in place before loading the next result.
`default_nettype none
module box_filter_2d_mean_unit #(
  parameter int unsigned MAX_KERNEL = 15,
  parameter int unsigned MAX_WIDTH  = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bfm_stream_if.sink                         in_ch,
  bfm_stream_if.source                       out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [bfm_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bfm_pkg::CfgDataW-1:0]  cfg_wdata
);
  import bfm_pkg::*;

  bfm_cmd_t      cmd;
  bfm_sts_t      sts;
  logic          in_ready;
  logic          out_valid;
  bfm_in_item_t  in_item;
  bfm_out_item_t out_item;

  assign in_item      = in_ch.data;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  bfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfm_datapath #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

// ----- tb/sv/tb_box_filter_2d_mean_unit.sv -----
`default_nettype none
module tb_box_filter_2d_mean_unit;
  import bfm_pkg::*;

  localparam int unsigned KMax     = 15;
  localparam int unsigned WMax     = 2048;
  localparam int unsigned SettleCy = 300;
  localparam int unsigned StuckCy  = 6000;

  typedef enum int {
    ROW_PIXEL,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    bfm_reg_t      idx;
    int unsigned   val;
    logic [7:0]    pix;
    bit            fs;
    bit            typed;
    bfm_out_item_t want;
  } stim_row_t;

  typedef struct {
    bit            typed;
    bfm_out_item_t want;
  } sent_pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  bfm_stream_if #(.payload_t(bfm_in_item_t)) in_ch ();
  bfm_stream_if #(.payload_t(bfm_out_item_t)) out_ch ();

  box_filter_2d_mean_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  logic [7:0] rows_mem [KMax][WMax];
  int unsigned col_pos, row_pos, slot_pos;
  int unsigned kern_sz, img_w, img_h;

  bfm_out_item_t pixels_due[$];
  sent_pixel_t   pixels_sent[$];
  stim_row_t     directed[$];
  int            mismatches = 0;
  int            idle_mode = 0;
  int            hold_off = 0;
  int            stuck_cycles = 0;

  function automatic int filter_pixel(input logic [7:0] px, input bit fs,
                                      output bfm_out_item_t res [2]);
    int unsigned w, h, half, c, r, sum, s;
    bit          filt, border;
    int          n;
    w = img_w;
    h = img_h;
    half = kern_sz / 2;
    filt = (kern_sz % 2 == 1) && (kern_sz <= KMax);
    n = 0;
    sum = 0;
    if (w == 0) w = 1;
    if (w > WMax) w = WMax;
    if (h == 0) h = 1;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      slot_pos = 0;
    end else begin
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        slot_pos = (slot_pos + 1) % KMax;
      end
      if (row_pos >= h) begin
        row_pos = 0;
        slot_pos = 0;
      end
    end
    c = col_pos;
    r = row_pos;
    rows_mem[slot_pos][c] = px;
    border = !filt || c < half || r < half || c + half >= w || r + half >= h;
    if (border) begin
      res[n] = '{pixel_out: px, out_col: c[10:0], out_row: r[15:0],
                 was_filtered: 1'b0, last_of_item: 1'b0};
      n++;
    end
    if (filt && c >= 2 * half && r >= 2 * half) begin
      for (int j = 0; j < kern_sz; j++) begin
        s = (slot_pos + KMax - j) % KMax;
        for (int i = c - 2 * half; i <= c; i++) sum += rows_mem[s][i];
      end
      res[n] = '{pixel_out: 8'(sum / (kern_sz * kern_sz)),
                 out_col: 11'(c - half), out_row: 16'(r - half),
                 was_filtered: 1'b1, last_of_item: 1'b0};
      n++;
    end
    if (n > 0) res[n-1].last_of_item = 1'b1;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      slot_pos = (slot_pos + 1) % KMax;
      if (row_pos >= h) begin
        row_pos = 0;
        slot_pos = 0;
      end
    end
    return n;
  endfunction

  always @(posedge clk) begin
    bfm_out_item_t res [2];
    bfm_out_item_t exp_item;
    sent_pixel_t   sp;
    int            n;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sp = pixels_sent.pop_front();
        n = filter_pixel(in_ch.data.pixel_in, in_ch.data.frame_start, res);
        if (sp.typed) pixels_due.push_back(sp.want);
        else for (int i = 0; i < n; i++) pixels_due.push_back(res[i]);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_ch.data);
          mismatches++;
        end else begin
          exp_item = pixels_due.pop_front();
          if (out_ch.data !== exp_item) begin
            $display("%0t: result mismatch, expected %p, actual %p",
                     $time, exp_item, out_ch.data);
            mismatches++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckCy) begin
        $display("box_filter_2d_mean_unit verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready = 1'b0;
      hold_off--;
    end else begin
      case (idle_mode)
        2: begin
          out_ch.ready = ($urandom_range(0, 99) >= 68);
        end
        3: begin
          out_ch.ready = ($urandom_range(0, 99) >= 13);
        end
        default: begin
          out_ch.ready = 1'b1;
        end
      endcase
    end
  end

  task automatic send_pixel(input logic [7:0] px, input bit fs, input bit typed,
                            input bfm_out_item_t want);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 68 : (idle_mode == 3) ? 13 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    pixels_sent.push_back('{typed: typed, want: want});
    in_ch.valid = 1'b1;
    in_ch.data = '{pixel_in: px, frame_start: fs};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (pixels_due.size() != 0 || pixels_sent.size() != 0) @(negedge clk);
    repeat (SettleCy) @(negedge clk);
  endtask

  task automatic write_reg(input bfm_reg_t idx, input int unsigned v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v[15:0];
    case (idx)
      REG_KERNEL_SIZE: kern_sz = v & 32'hF;
      REG_IMAGE_WIDTH: img_w = v & 32'hFFF;
      default: img_h = v & 32'hFFFF;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_cfg(input bfm_reg_t idx, input int unsigned v);
    directed.push_back('{kind: ROW_CFG, idx: idx, val: v, pix: '0, fs: 1'b0,
                         typed: 1'b0, want: '0});
  endtask

  task automatic add_px(input logic [7:0] px, input bit fs, input bit typed,
                        input bfm_out_item_t want);
    directed.push_back('{kind: ROW_PIXEL, idx: REG_KERNEL_SIZE, val: 0, pix: px,
                         fs: fs, typed: typed, want: want});
  endtask

  initial begin
    stim_row_t     row;
    bfm_out_item_t none;
    int            total, count, k;
    bit            cfg_seen;
    none = '0;
    kern_sz = KernelReset;
    img_w = WidthReset;
    img_h = HeightReset;
    col_pos = 0;
    row_pos = 0;
    slot_pos = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;

    add_px(8'hFF, 1'b1, 1'b1, '{8'hFF, 11'd0, 16'd0, 1'b0, 1'b1});
    add_px(8'h00, 1'b0, 1'b1, '{8'h00, 11'd1, 16'd0, 1'b0, 1'b1});
    add_cfg(REG_KERNEL_SIZE, 1);
    add_cfg(REG_IMAGE_WIDTH, 3);
    add_cfg(REG_IMAGE_HEIGHT, 2);
    add_px(8'hA5, 1'b1, 1'b1, '{8'hA5, 11'd0, 16'd0, 1'b1, 1'b1});
    add_px(8'h5A, 1'b0, 1'b1, '{8'h5A, 11'd1, 16'd0, 1'b1, 1'b1});
    add_px(8'h3C, 1'b0, 1'b0, none);
    add_px(8'hC3, 1'b0, 1'b0, none);
    add_cfg(REG_KERNEL_SIZE, 4);
    add_px(8'h80, 1'b1, 1'b1, '{8'h80, 11'd0, 16'd0, 1'b0, 1'b1});
    add_cfg(REG_KERNEL_SIZE, 15);
    add_px(8'h07, 1'b1, 1'b1, '{8'h07, 11'd0, 16'd0, 1'b0, 1'b1});
    add_cfg(REG_KERNEL_SIZE, 3);
    add_cfg(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 9; i++) add_px(8'hFF, i == 0, 1'b0, none);
    add_cfg(REG_IMAGE_WIDTH, 0);
    add_cfg(REG_IMAGE_HEIGHT, 0);
    add_px(8'h01, 1'b0, 1'b0, none);
    add_px(8'hFE, 1'b0, 1'b0, none);
    add_cfg(REG_KERNEL_SIZE, 0);
    add_cfg(REG_IMAGE_WIDTH, 4095);
    add_cfg(REG_IMAGE_HEIGHT, 65535);
    add_px(8'h55, 1'b1, 1'b0, none);
    add_px(8'hAA, 1'b0, 1'b0, none);
    add_cfg(REG_KERNEL_SIZE, 2);
    add_cfg(REG_IMAGE_WIDTH, 2048);
    add_px(8'h12, 1'b0, 1'b0, none);

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    cfg_seen = 1'b0;
    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_seen) settle();
        write_reg(row.idx, row.val);
        cfg_seen = 1'b1;
      end else begin
        send_pixel(row.pix, row.fs, row.typed, row.want);
        cfg_seen = 1'b0;
      end
    end

    total = 0;
    for (int ph = 0; total < 500; ph++) begin
      settle();
      idle_mode = ph % 4;
      case ($urandom_range(0, 5))
        0: k = 1;
        1: k = 3;
        2: k = 5;
        3: k = 15;
        4: k = 2 * $urandom_range(0, 7);
        default: k = 2 * $urandom_range(0, 7) + 1;
      endcase
      write_reg(REG_KERNEL_SIZE, k);
      write_reg(REG_IMAGE_WIDTH, $urandom_range(1, (k >= 9) ? 20 : 12));
      write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, (k >= 9) ? 18 : 10));
      if (ph == 2) hold_off = 400;
      count = $urandom_range(40, 80);
      for (int i = 0; i < count; i++) begin
        send_pixel(8'($urandom), (i == 0) || ($urandom_range(0, 49) == 0), 1'b0, none);
        total++;
      end
    end

    in_ch.valid = 1'b0;
    while (pixels_due.size() != 0 || pixels_sent.size() != 0) @(negedge clk);
    repeat (SettleCy) @(negedge clk);
    if (mismatches == 0) begin
      $display("box_filter_2d_mean_unit verification clean");
    end else begin
      $display("box_filter_2d_mean_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
